@@ sv/dac_pkg.sv @@
// Package for the decimal accumulator machine: item kinds, operation codes
// and shared constants. No dependencies.
`timescale 1ns / 1ps
package dac_pkg;
    localparam int WORD_BITS = 32;
    localparam int MEM_WORDS = 100;
    localparam int ADDR_W = 7;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_START = 2'd1,
        K_STEP  = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    localparam logic [6:0] OP_NOP   = 7'd0;
    localparam logic [6:0] OP_LOAD  = 7'd11;
    localparam logic [6:0] OP_STORE = 7'd12;
    localparam logic [6:0] OP_ADD   = 7'd21;
    localparam logic [6:0] OP_RSUB  = 7'd22;
    localparam logic [6:0] OP_MUL   = 7'd23;
    localparam logic [6:0] OP_DIV   = 7'd24;
    localparam logic [6:0] OP_MOD   = 7'd25;
    localparam logic [6:0] OP_IN    = 7'd31;
    localparam logic [6:0] OP_OUT   = 7'd41;
    localparam logic [6:0] OP_JMP   = 7'd51;
    localparam logic [6:0] OP_JGT   = 7'd52;
    localparam logic [6:0] OP_JGE   = 7'd53;
    localparam logic [6:0] OP_JLT   = 7'd54;
    localparam logic [6:0] OP_JLE   = 7'd55;
    localparam logic [6:0] OP_JNE   = 7'd56;
    localparam logic [6:0] OP_JEQ   = 7'd57;
    localparam logic [6:0] OP_SHL   = 7'd61;
    localparam logic [6:0] OP_SHR   = 7'd62;
    localparam logic [6:0] OP_HALT  = 7'd70;

    // Instruction words from here upwards decode to codes that do nothing.
    localparam int WORD_OP_LIMIT = (int'(OP_HALT) + 1) * MEM_WORDS;
endpackage

@@ sv/dac_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/dac_divider.sv @@
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module dac_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] r_q;
    logic [W-1:0] r_r;
    logic [W-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic         r_busy;
    logic [W:0]   n_trial;

    assign n_trial = {r_r, r_q[W-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                if (n_trial[W]) begin
                    r_r <= {r_r[W-2:0], r_q[W-1]};
                    r_q <= {r_q[W-2:0], 1'b0};
                end else begin
                    r_r <= n_trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

@@ sv/decimal_accumulator_cpu.sv @@
// Decimal accumulator machine: 100-word memory in a synchronous RAM, one
// instruction per step transfer. A write or start transfer goes straight to
// the result, a read through the RAM read, a step through fetch, split (not
// for a negative word), operand, multiply and execute, or straight on when
// stopped; divide and remainder wait on the bit-serial divider. One item is
// in flight. Reset: a pass clears the memory; acc and pc zero, stopped.
`timescale 1ns / 1ps
module decimal_accumulator_cpu
    import dac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_opcode,
    input  logic [6:0]           i_address,
    input  logic signed [31:0]   i_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_read_data,
    output logic                 o_print_valid,
    output logic signed [31:0]   o_print_value,
    output logic                 o_input_taken,
    output logic                 o_halted,
    output logic                 o_fault,
    output logic [6:0]           o_program_counter,
    output logic signed [31:0]   o_accumulator_value
);
    localparam int W = WORD_BITS;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_FETCH, S_SPLIT, S_OPER, S_EXEC,
        S_DIVW, S_DIVFIX, S_MULW, S_OUT
    } t_state;

    t_state r_state;
    logic [6:0]   r_clr;
    logic [6:0]   r_addr;
    logic [W-1:0] r_val;
    logic [W-1:0] r_acc;
    logic [6:0]   r_pc;
    logic         r_stop;
    logic         r_fault;
    logic [6:0]   r_op;
    logic [6:0]   r_a;
    logic [W-1:0] r_mv;
    logic [W-1:0] r_prod;
    logic [W-1:0] r_amag;
    logic [W-1:0] r_q10;
    logic [W-1:0] r_rdata;
    logic         r_pv;
    logic [W-1:0] r_pval;
    logic         r_it;

    logic         n_we;
    logic [6:0]   n_waddr;
    logic [W-1:0] n_wdata;
    logic [6:0]   n_raddr;
    logic [W-1:0] w_rdata;

    dac_ram #(.WIDTH(W), .DEPTH(128)) u_mem (
        .i_clk  (i_clk),
        .i_we   (n_we),
        .i_waddr(n_waddr),
        .i_wdata(n_wdata),
        .i_raddr(n_raddr),
        .o_rdata(w_rdata)
    );

    logic         n_dstart;
    logic [W-1:0] n_dnum;
    logic [W-1:0] n_dden;
    logic         w_ddone;
    logic [W-1:0] w_quot;
    logic [W-1:0] w_rem;

    dac_divider #(.W(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(n_dstart),
        .i_num  (n_dnum),
        .i_den  (n_dden),
        .o_done (w_ddone),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (W)'(-v) : v;
    endfunction

    // The instruction word split: only words below the first code past halt
    // matter, so a reciprocal multiply on 13 bits gives quotient and remainder.
    logic [25:0] w_split_prod;
    logic [6:0]  w_q100;
    logic [6:0]  w_a100;
    assign w_split_prod = 26'(r_mv[12:0]) * 26'(5243);
    assign w_q100       = w_split_prod[25:19];
    assign w_a100       = 7'(r_mv[12:0] - 13'(w_q100) * 13'(MEM_WORDS));

    // Division by ten of the accumulator magnitude by reciprocal multiply.
    logic [63:0] w_q10_prod;
    assign w_q10_prod = 64'(r_amag) * 64'(32'hCCCC_CCCD);

    logic w_acc_neg, w_acc_zero, w_mv_neg;
    assign w_acc_neg  = r_acc[W-1];
    assign w_acc_zero = (r_acc == '0);
    assign w_mv_neg   = r_mv[W-1];

    logic [7:0] n_next;
    logic       n_take;
    always_comb begin
        n_take = 1'b0;
        unique case (r_op)
            OP_JMP: n_take = 1'b1;
            OP_JGT: n_take = !w_acc_neg && !w_acc_zero;
            OP_JGE: n_take = !w_acc_neg;
            OP_JLT: n_take = w_acc_neg;
            OP_JLE: n_take = w_acc_neg || w_acc_zero;
            OP_JNE: n_take = !w_acc_zero;
            OP_JEQ: n_take = w_acc_zero;
            default: n_take = 1'b0;
        endcase
        n_next = n_take ? {1'b0, r_a} : {1'b0, r_pc} + 8'd1;
    end

    always_comb begin
        n_we     = 1'b0;
        n_waddr  = r_addr;
        n_wdata  = r_val;
        n_raddr  = r_addr;
        n_dstart = 1'b0;
        n_dnum   = mag(r_acc);
        n_dden   = mag(r_mv);
        unique case (r_state)
            S_CLEAR: begin
                n_we = 1'b1;
                n_waddr = r_clr;
                n_wdata = '0;
            end
            S_IDLE: begin
                n_we = i_valid && i_opcode == K_WRITE && i_address < 7'(MEM_WORDS);
                n_waddr = i_address;
                n_wdata = W'(signed'(i_value));
                n_raddr = (i_opcode == K_STEP) ? r_pc : i_address;
            end
            S_OPER: n_raddr = r_a;
            S_EXEC: begin
                n_raddr = r_a;
                if (r_op == OP_STORE) begin
                    n_we = 1'b1; n_waddr = r_a; n_wdata = r_acc;
                end else if (r_op == OP_IN) begin
                    n_we = 1'b1; n_waddr = r_a; n_wdata = r_val;
                end
                if ((r_op == OP_DIV || r_op == OP_MOD) && r_mv != '0) begin
                    n_dstart = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_acc   <= '0;
            r_pc    <= '0;
            r_stop  <= 1'b1;
            r_fault <= 1'b0;
            o_valid <= 1'b0;
            o_stall <= 1'b1;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 7'd1;
                    if (r_clr == 7'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                        o_stall <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        o_stall <= 1'b1;
                        r_addr <= i_address;
                        r_val  <= W'(signed'(i_value));
                        r_pv <= 1'b0; r_pval <= '0; r_it <= 1'b0; r_rdata <= '0;
                        unique case (t_kind'(i_opcode))
                            K_WRITE: r_state <= S_OUT;
                            K_START: begin
                                r_pc <= '0; r_stop <= 1'b0; r_state <= S_OUT;
                            end
                            K_READ: r_state <= S_READ;
                            K_STEP: r_state <= r_stop ? S_OUT : S_FETCH;
                        endcase
                    end
                end
                S_READ: begin
                    if (r_addr < 7'(MEM_WORDS)) r_rdata <= w_rdata;
                    r_state <= S_OUT;
                end
                S_FETCH: begin
                    r_mv <= w_rdata;
                    r_state <= S_SPLIT;
                    r_op <= OP_NOP; r_a <= '0;
                    if (w_rdata[W-1]) r_state <= S_OPER;
                end
                S_SPLIT: begin
                    if (r_mv < W'(WORD_OP_LIMIT)) begin
                        r_op <= w_q100;
                        r_a  <= w_a100;
                    end
                    r_state <= S_OPER;
                end
                S_OPER: begin
                    r_amag <= mag(r_acc);
                    r_state <= S_MULW;
                end
                S_MULW: begin
                    r_mv <= w_rdata;
                    r_prod <= r_acc * w_rdata;
                    r_q10 <= W'(w_q10_prod[63:35]);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    unique case (r_op)
                        OP_LOAD: r_acc <= r_mv;
                        OP_ADD:  r_acc <= r_acc + r_mv;
                        OP_RSUB: r_acc <= r_mv - r_acc;
                        OP_MUL:  r_acc <= r_prod;
                        OP_IN:   r_it <= 1'b1;
                        OP_OUT:  begin r_pv <= 1'b1; r_pval <= r_mv; end
                        OP_SHL:  r_acc <= r_acc * W'(10);
                        OP_SHR:  r_acc <= w_acc_neg ? W'(-r_q10) : r_q10;
                        OP_HALT: r_stop <= 1'b1;
                        default: ;
                    endcase
                    if ((r_op == OP_DIV || r_op == OP_MOD) && r_mv == '0) begin
                        r_fault <= 1'b1;
                        r_stop <= 1'b1;
                    end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                        r_state <= S_DIVW;
                    end
                    if (n_next >= 8'(MEM_WORDS)) begin
                        r_pc <= 7'(MEM_WORDS - 1);
                        if (r_op != OP_HALT && !((r_op == OP_DIV || r_op == OP_MOD)
                                && r_mv == '0)) begin
                            r_fault <= 1'b1;
                            r_stop <= 1'b1;
                        end
                    end else begin
                        r_pc <= n_next[6:0];
                    end
                end
                S_DIVW: if (w_ddone) r_state <= S_DIVFIX;
                S_DIVFIX: begin
                    if (r_op == OP_MOD) begin
                        r_acc <= w_acc_neg ? W'(-w_rem) : w_rem;
                    end else begin
                        r_acc <= (w_acc_neg != w_mv_neg) ? W'(-w_quot) : w_quot;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    if (o_valid && !i_stall) begin
                        o_valid <= 1'b0;
                        o_stall <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_read_data         = r_rdata[31:0];
    assign o_print_valid       = r_pv;
    assign o_print_value       = r_pval[31:0];
    assign o_input_taken       = r_it;
    assign o_halted            = r_stop;
    assign o_fault             = r_fault;
    assign o_program_counter   = r_pc;
    assign o_accumulator_value = r_acc[31:0];

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < 7'(MEM_WORDS)) else $error("pc out of range");
    a_fault_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fault) |-> r_stop) else $error("fault without stop");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accepting while result pending");
endmodule
